// ===== rtl/core/kbi_pkg.sv =====
package kbi_pkg;

  localparam int CORDIC_ITERS = 20;
  localparam int CW  = 50;
  localparam int ZW  = 34;
  localparam int PW  = 66;
  localparam int MBW = 17;
  localparam int DW  = 63;

  localparam logic signed [ZW-1:0] CORDIC_START = 34'sd652032874;
  localparam logic signed [ZW-1:0] ANG_QTR      = 34'sd1073741824;
  localparam logic signed [ZW-1:0] ANG_HALF     = 34'sd2147483648;
  localparam logic signed [14:0]   STEER_LIMIT  = 15'sd14563;
  localparam logic [14:0]          INV_GAIN_Q15 = 15'd19898;
  localparam logic [14:0]          TWO_PI_Q12   = 15'd25736;

  localparam logic [1:0] CFG_WHEELBASE = 2'd0;
  localparam logic [1:0] CFG_REAR_OFS  = 2'd1;
  localparam logic [1:0] CFG_STEP_TIME = 2'd2;

  typedef enum logic [3:0] {
    OP_LOAD, OP_SC_STEER, OP_MUL_A, OP_MUL_B, OP_VEC, OP_MUL_R, OP_MUL_RP, OP_SC_DIR,
    OP_MUL_XV, OP_MUL_XT, OP_MUL_YV, OP_MUL_YT, OP_MUL_NV, OP_MUL_NT, OP_DIV, OP_PUB
  } op_t;

  typedef enum logic [1:0] {S_IDLE, S_ISSUE, S_WAIT, S_PUB} state_t;

  typedef struct packed {
    logic start;
    op_t  op;
  } cmd_t;

  typedef struct packed {
    logic done;
  } sts_t;

  function automatic logic signed [ZW-1:0] atan_lut(input logic [4:0] idx);
    logic signed [ZW-1:0] v;
    case (idx)
      5'd0:    v = 34'sh020000000;
      5'd1:    v = 34'sh012E4051E;
      5'd2:    v = 34'sh009FB385B;
      5'd3:    v = 34'sh0051111D4;
      5'd4:    v = 34'sh0028B0D43;
      5'd5:    v = 34'sh00145D7E1;
      5'd6:    v = 34'sh000A2F61E;
      5'd7:    v = 34'sh000517C55;
      5'd8:    v = 34'sh00028BE53;
      5'd9:    v = 34'sh000145F2F;
      5'd10:   v = 34'sh0000A2F98;
      5'd11:   v = 34'sh0000517CC;
      5'd12:   v = 34'sh000028BE6;
      5'd13:   v = 34'sh0000145F3;
      5'd14:   v = 34'sh00000A2FA;
      5'd15:   v = 34'sh00000517D;
      5'd16:   v = 34'sh0000028BE;
      5'd17:   v = 34'sh00000145F;
      5'd18:   v = 34'sh000000A30;
      5'd19:   v = 34'sh000000518;
      default: v = '0;
    endcase
    return v;
  endfunction

endpackage

// ===== rtl/core/kbi_cordic.sv =====
module kbi_cordic (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         start,
  input  logic                         vec,
  input  logic signed [kbi_pkg::CW-1:0] x0,
  input  logic signed [kbi_pkg::CW-1:0] y0,
  input  logic signed [kbi_pkg::ZW-1:0] z0,
  output logic                         done,
  output logic signed [kbi_pkg::CW-1:0] x,
  output logic signed [kbi_pkg::CW-1:0] y,
  output logic signed [kbi_pkg::ZW-1:0] z
);
  import kbi_pkg::*;

  localparam logic [4:0] LAST = 5'(CORDIC_ITERS - 1);

  logic signed [CW-1:0] x_r, y_r, dx, dy;
  logic signed [ZW-1:0] z_r, at;
  logic [4:0] i_r;
  logic busy_r, vec_r, done_r, pos;

  assign dx  = y_r >>> i_r;
  assign dy  = x_r >>> i_r;
  assign at  = atan_lut(i_r);
  assign pos = vec_r ? (y_r >= 0) : (z_r >= 0);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      i_r    <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        i_r    <= '0;
      end else if (busy_r) begin
        i_r <= i_r + 5'd1;
        if (i_r == LAST) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      x_r   <= x0;
      y_r   <= y0;
      z_r   <= z0;
      vec_r <= vec;
    end else if (busy_r) begin
      if (vec_r) begin
        x_r <= pos ? x_r + dx : x_r - dx;
        y_r <= pos ? y_r - dy : y_r + dy;
        z_r <= pos ? z_r + at : z_r - at;
      end else begin
        x_r <= pos ? x_r - dx : x_r + dx;
        y_r <= pos ? y_r + dy : y_r - dy;
        z_r <= pos ? z_r - at : z_r + at;
      end
    end
  end

  assign done = done_r;
  assign x    = x_r;
  assign y    = y_r;
  assign z    = z_r;

endmodule

// ===== rtl/core/kbi_ctrl.sv =====
module kbi_ctrl (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_tvalid,
  output logic          in_tready,
  output logic          out_tvalid,
  input  logic          out_tready,
  output kbi_pkg::cmd_t cmd,
  input  kbi_pkg::sts_t sts
);
  import kbi_pkg::*;

  state_t state_r, state_nxt;
  op_t    op_r, op_nxt;
  logic   out_valid_r, out_valid_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      op_r        <= OP_LOAD;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      op_r        <= op_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_comb begin
    state_nxt     = state_r;
    op_nxt        = op_r;
    out_valid_nxt = out_valid_r & ~out_tready;
    in_tready     = 1'b0;
    cmd.start     = 1'b0;
    cmd.op        = op_r;
    unique case (state_r)
      S_IDLE: begin
        in_tready = 1'b1;
        if (in_tvalid) begin
          cmd.start = 1'b1;
          cmd.op    = OP_LOAD;
          op_nxt    = OP_SC_STEER;
          state_nxt = S_ISSUE;
        end
      end
      S_ISSUE: begin
        cmd.start = 1'b1;
        state_nxt = S_WAIT;
      end
      S_WAIT: begin
        if (sts.done) begin
          if (op_r == OP_DIV) begin
            state_nxt = S_PUB;
          end else begin
            op_nxt    = op_t'(4'(op_r) + 4'd1);
            state_nxt = S_ISSUE;
          end
        end
      end
      S_PUB: begin
        if (!out_valid_r || out_tready) begin
          cmd.start     = 1'b1;
          cmd.op        = OP_PUB;
          out_valid_nxt = 1'b1;
          state_nxt     = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  assign out_tvalid = out_valid_r;

endmodule

// ===== rtl/core/kbi_dp.sv =====
module kbi_dp (
  input  logic               clk,
  input  logic               rst_n,
  input  kbi_pkg::cmd_t      cmd,
  output kbi_pkg::sts_t      sts,
  input  logic signed [14:0] steer_angle,
  input  logic signed [15:0] speed,
  input  logic               cfg_we,
  input  logic [1:0]         cfg_index,
  input  logic [15:0]        cfg_data,
  output logic signed [31:0] pos_x,
  output logic signed [31:0] pos_y,
  output logic [15:0]        heading
);
  import kbi_pkg::*;

  localparam logic [4:0] MB_LAST = 5'(MBW - 1);
  localparam logic [5:0] DV_LAST = 6'(DW - 1);
  localparam logic signed [PW-1:0] POS_RND = PW'(64'sd1 <<< 37);
  localparam logic signed [PW-1:0] S32_MAX = PW'(64'sd2147483647);
  localparam logic signed [PW-1:0] S32_MIN = -PW'(64'sd2147483648);

  logic [15:0] wb_r, rao_r, dt_r, wb_eff;
  logic signed [31:0] x_r, y_r, ox_r, oy_r;
  logic [15:0] hd_r, oh_r;
  logic signed [14:0] steer_r;
  logic signed [15:0] v_r;
  op_t op_r;
  logic flip_r;
  logic signed [ZW-1:0] cs_r, sn_r, ch_r, sh_r, beta_r;
  logic signed [CW-1:0] a_r, b_r, mag_r, r_r;
  logic [DW-1:0] rp_r;
  logic signed [PW-1:0] t_r;

  // serial multiplier
  logic signed [PW-1:0] mc_r, acc_r, term, acc_sum;
  logic [MBW-1:0] mb_r;
  logic [4:0] mcnt_r;
  logic mbusy_r, m_fin;
  logic signed [PW-1:0] ma;
  logic [MBW-1:0] mbv;

  // restoring divider
  logic [DW-1:0] dn_r, dd_r;
  logic [DW:0] rem_r, rem2;
  logic [15:0] q_r, qn;
  logic [5:0] dcnt_r;
  logic dbusy_r, dneg_r, d_fin, ge;
  logic signed [PW-1:0] absn;

  // cordic
  logic c_start, c_vec, c_done;
  logic signed [CW-1:0] c_x0, c_y0, c_x, c_y, cfx, cfy;
  logic signed [ZW-1:0] c_z0, c_z, zs;
  logic [31:0] ang32;
  logic fold;

  logic signed [PW-1:0] pxy, sxy, sat_xy, rp_raw;
  logic signed [31:0] base_xy;

  assign wb_eff = (wb_r == 16'd0) ? 16'd1 : wb_r;

  always_comb begin
    ang32 = (cmd.op == OP_SC_STEER) ? 32'({{2{steer_r[14]}}, steer_r[13:0], 16'h0})
                                    : ({hd_r, 16'h0} + beta_r[31:0]);
    zs    = ZW'($signed(ang32));
    fold  = 1'b0;
    if (zs > ANG_QTR) begin
      zs   = zs - ANG_HALF;
      fold = 1'b1;
    end else if (zs < -ANG_QTR) begin
      zs   = zs + ANG_HALF;
      fold = 1'b1;
    end
  end

  assign c_start = cmd.start &&
                   (cmd.op == OP_SC_STEER || cmd.op == OP_SC_DIR || cmd.op == OP_VEC);
  assign c_vec   = (cmd.op == OP_VEC);
  assign c_x0    = c_vec ? a_r : CW'(CORDIC_START);
  assign c_y0    = c_vec ? b_r : '0;
  assign c_z0    = c_vec ? '0 : zs;

  kbi_cordic u_cordic (
    .clk  (clk),
    .rst_n(rst_n),
    .start(c_start),
    .vec  (c_vec),
    .x0   (c_x0),
    .y0   (c_y0),
    .z0   (c_z0),
    .done (c_done),
    .x    (c_x),
    .y    (c_y),
    .z    (c_z)
  );

  assign cfx = flip_r ? -c_x : c_x;
  assign cfy = flip_r ? -c_y : c_y;

  always_comb begin
    ma  = '0;
    mbv = '0;
    case (cmd.op)
      OP_MUL_A:  begin ma = PW'(cs_r);  mbv = {1'b0, wb_eff};       end
      OP_MUL_B:  begin ma = PW'(sn_r);  mbv = {1'b0, rao_r};        end
      OP_MUL_R:  begin ma = PW'(mag_r); mbv = MBW'(INV_GAIN_Q15);   end
      OP_MUL_RP: begin ma = PW'(r_r);   mbv = MBW'(TWO_PI_Q12);     end
      OP_MUL_XV: begin ma = PW'(ch_r);  mbv = MBW'(v_r);            end
      OP_MUL_YV: begin ma = PW'(sh_r);  mbv = MBW'(v_r);            end
      OP_MUL_NV: begin ma = PW'(sn_r);  mbv = MBW'(v_r);            end
      OP_MUL_XT, OP_MUL_YT, OP_MUL_NT: begin
        ma  = t_r;
        mbv = {1'b0, dt_r};
      end
      default: begin ma = '0; mbv = '0; end
    endcase
  end

  // top bit of the multiplier operand carries negative weight
  assign term    = mb_r[0] ? ((mcnt_r == MB_LAST) ? -mc_r : mc_r) : '0;
  assign acc_sum = acc_r + term;
  assign m_fin   = mbusy_r && (mcnt_r == MB_LAST);

  assign rem2  = {rem_r[DW-1:0], dn_r[DW-1]};
  assign ge    = (rem2 >= {1'b0, dd_r});
  assign qn    = {q_r[14:0], ge};
  assign d_fin = dbusy_r && (dcnt_r == DV_LAST);
  assign absn  = (t_r < 0) ? -t_r : t_r;

  assign base_xy = (op_r == OP_MUL_XT) ? x_r : y_r;
  assign pxy     = (acc_sum + POS_RND) >>> 38;
  assign sxy     = PW'(base_xy) + pxy;
  assign sat_xy  = (sxy > S32_MAX) ? S32_MAX : ((sxy < S32_MIN) ? S32_MIN : sxy);
  assign rp_raw  = acc_sum >>> 12;

  assign sts.done = c_done | m_fin | d_fin;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wb_r    <= 16'd512;
      rao_r   <= 16'd256;
      dt_r    <= 16'd655;
      x_r     <= '0;
      y_r     <= '0;
      hd_r    <= '0;
      mbusy_r <= 1'b0;
      dbusy_r <= 1'b0;
    end else begin
      if (cfg_we) begin
        unique case (cfg_index)
          CFG_WHEELBASE: wb_r  <= cfg_data;
          CFG_REAR_OFS:  rao_r <= cfg_data;
          CFG_STEP_TIME: dt_r  <= cfg_data;
          default: ;
        endcase
      end
      if (cmd.start) begin
        op_r <= cmd.op;
        unique case (cmd.op)
          OP_LOAD: begin
            steer_r <= (steer_angle > STEER_LIMIT) ? STEER_LIMIT :
                       ((steer_angle < -STEER_LIMIT) ? -STEER_LIMIT : steer_angle);
            v_r     <= speed;
          end
          OP_SC_STEER, OP_SC_DIR: flip_r <= fold;
          OP_VEC: flip_r <= 1'b0;
          OP_DIV: begin
            dbusy_r <= 1'b1;
            dcnt_r  <= '0;
            dneg_r  <= t_r[PW-1];
            dn_r    <= absn[DW-1:0] + {1'b0, rp_r[DW-1:1]};
            dd_r    <= rp_r;
            rem_r   <= '0;
            q_r     <= '0;
          end
          OP_PUB: begin
            ox_r <= x_r;
            oy_r <= y_r;
            oh_r <= hd_r;
          end
          default: begin
            mbusy_r <= 1'b1;
            mcnt_r  <= '0;
            mc_r    <= ma;
            mb_r    <= mbv;
            acc_r   <= '0;
          end
        endcase
      end
      if (mbusy_r) begin
        acc_r  <= acc_sum;
        mc_r   <= mc_r <<< 1;
        mb_r   <= mb_r >> 1;
        mcnt_r <= mcnt_r + 5'd1;
        if (m_fin) begin
          mbusy_r <= 1'b0;
          case (op_r)
            OP_MUL_A:  a_r  <= CW'(acc_sum);
            OP_MUL_B:  b_r  <= CW'(acc_sum);
            OP_MUL_R:  r_r  <= CW'(acc_sum >>> 15);
            OP_MUL_RP: rp_r <= (rp_raw < 1) ? DW'(1) : rp_raw[DW-1:0];
            OP_MUL_XT: x_r  <= sat_xy[31:0];
            OP_MUL_YT: y_r  <= sat_xy[31:0];
            default:   t_r  <= acc_sum;
          endcase
        end
      end
      if (dbusy_r) begin
        rem_r  <= ge ? (rem2 - {1'b0, dd_r}) : rem2;
        q_r    <= qn;
        dn_r   <= dn_r << 1;
        dcnt_r <= dcnt_r + 6'd1;
        if (d_fin) begin
          dbusy_r <= 1'b0;
          hd_r    <= hd_r + (dneg_r ? -qn : qn);
        end
      end
      if (c_done) begin
        case (op_r)
          OP_SC_STEER: begin cs_r <= ZW'(cfx); sn_r <= ZW'(cfy); end
          OP_SC_DIR:   begin ch_r <= ZW'(cfx); sh_r <= ZW'(cfy); end
          default:     begin beta_r <= c_z; mag_r <= c_x; end
        endcase
      end
    end
  end

  assign pos_x   = ox_r;
  assign pos_y   = oy_r;
  assign heading = oh_r;

endmodule

// ===== rtl/core/kinematic_bicycle_integrator_core.sv =====
// Kinematic bicycle pose integrator. Each accepted item (steering angle, speed)
// advances the stored pose by one Euler step of step_time and returns the new
// pose: x and y in saturating signed Q16.16 metres, heading as a wrapping
// 16-bit binary angle. One item is in work at a time, and the next item is
// taken once its result has been published. The work is three passes of the
// shared 20-iteration CORDIC, ten passes of the 17-bit serial multiplier and
// one 63-bit restoring divide for the heading increment, plus the accept and
// publish steps; publishing waits until the output slot is free. The next item
// is taken while the previous result still waits on the output. Configuration
// writes must happen while the block is idle.
module kinematic_bicycle_integrator_core (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [31:0] in_tdata,   // steer_angle[14:0], speed[30:15], zero pad
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [79:0] out_tdata,  // pos_x[31:0], pos_y[63:32], heading[79:64]
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [15:0] cfg_data
);
  import kbi_pkg::*;

  cmd_t cmd;
  sts_t sts;
  logic signed [31:0] pos_x, pos_y;
  logic [15:0] heading;

  kbi_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .cmd       (cmd),
    .sts       (sts)
  );

  kbi_dp u_dp (
    .clk        (clk),
    .rst_n      (rst_n),
    .cmd        (cmd),
    .sts        (sts),
    .steer_angle($signed(in_tdata[14:0])),
    .speed      ($signed(in_tdata[30:15])),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .pos_x      (pos_x),
    .pos_y      (pos_y),
    .heading    (heading)
  );

  assign out_tdata = {heading, pos_y, pos_x};

`ifndef SYNTH
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |=> !in_tready)
    else $error("input accepted while an item is in work");

  a_load_on_accept: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.start && cmd.op == OP_LOAD |-> in_tvalid && in_tready)
    else $error("operand load without an accepted item");

  a_publish_slot_free: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.start && cmd.op == OP_PUB |-> !out_tvalid || out_tready)
    else $error("result overwritten before it was taken");
`endif

endmodule

// ===== tb/testbench.sv =====
module testbench;
  timeunit 1ns;
  timeprecision 1ps;
  import kbi_pkg::*;

  logic        clk;
  logic        rst_n;
  logic        in_tvalid;
  logic        in_tready;
  logic [31:0] in_tdata;
  logic        out_tvalid;
  logic        out_tready;
  logic [79:0] out_tdata;
  logic        cfg_we;
  logic [1:0]  cfg_index;
  logic [15:0] cfg_data;

  kinematic_bicycle_integrator_core dut (.*);

  typedef struct {
    logic [31:0] x;
    logic [31:0] y;
    logic [15:0] hd;
  } pose_t;

  logic [31:0] steer_q[$];
  pose_t       pose_q[$];
  int          errors = 0;
  int          in_idle_pct = 33;
  int          out_idle_pct = 33;
  int          results_seen = 0;
  int          hold_left = 0;
  bit          hold_done = 0;

  // predictor state
  logic [15:0] m_wheelbase, m_rear, m_dt;
  logic signed [31:0] m_x, m_y;
  logic [15:0] m_hd;

  longint atan_steps[20] = '{
    64'h20000000, 64'h12E4051E, 64'h09FB385B, 64'h051111D4, 64'h028B0D43,
    64'h0145D7E1, 64'h00A2F61E, 64'h00517C55, 64'h0028BE53, 64'h00145F2F,
    64'h000A2F98, 64'h000517CC, 64'h00028BE6, 64'h000145F3, 64'h0000A2FA,
    64'h0000517D, 64'h000028BE, 64'h0000145F, 64'h00000A30, 64'h00000518};

  always begin
    clk = 1'b1; #6;
    clk = 1'b0; #6;
  end

  function automatic void rotate(input logic [31:0] ang, output longint c, output longint s);
    longint z, x, y, dx, dy;
    bit flip;
    z = longint'({32'b0, ang});
    x = 652032874;
    y = 0;
    flip = 0;
    if (z >= 64'sd2147483648) z -= 64'sd4294967296;
    if (z > 64'sd1073741824) begin
      z -= 64'sd2147483648; flip = 1;
    end else if (z < -64'sd1073741824) begin
      z += 64'sd2147483648; flip = 1;
    end
    for (int i = 0; i < 20; i++) begin
      dx = y >>> i;
      dy = x >>> i;
      if (z >= 0) begin
        x -= dx; y += dy; z -= atan_steps[i];
      end else begin
        x += dx; y -= dy; z += atan_steps[i];
      end
    end
    if (flip) begin
      x = -x; y = -y;
    end
    c = x;
    s = y;
  endfunction

  function automatic void vectorize(input longint a, input longint b,
                                    output longint ang, output longint mag);
    longint x, y, z, dx, dy;
    x = a; y = b; z = 0;
    for (int i = 0; i < 20; i++) begin
      dx = y >>> i;
      dy = x >>> i;
      if (y >= 0) begin
        x += dx; y -= dy; z += atan_steps[i];
      end else begin
        x -= dx; y += dy; z -= atan_steps[i];
      end
    end
    ang = z;
    mag = x;
  endfunction

  function automatic logic signed [31:0] sat_add(input logic signed [31:0] b, input longint d);
    longint r;
    r = longint'(b) + d;
    if (r > 64'sd2147483647) return 32'sh7FFFFFFF;
    if (r < -64'sd2147483648) return 32'sh80000000;
    return r[31:0];
  endfunction

  function automatic pose_t advance_pose(input logic [31:0] item);
    logic signed [14:0] st_raw;
    logic signed [15:0] sp_raw;
    longint steer, v, lw, dt, cs, sn, beta, mag, r, rp, num, dh, ch, sh, dxp, dyp;
    logic [31:0] a, dir;
    pose_t p;
    st_raw = item[14:0];
    sp_raw = item[30:15];
    steer = st_raw;
    v = sp_raw;
    lw = (m_wheelbase == 0) ? 1 : longint'(m_wheelbase);
    dt = longint'(m_dt);
    if (steer > 14563) steer = 14563;
    if (steer < -14563) steer = -14563;
    a = 32'(steer) << 16;
    rotate(a, cs, sn);
    vectorize(lw * cs, longint'(m_rear) * sn, beta, mag);
    r = (mag * 19898) >>> 15;
    rp = (r * 25736) >>> 12;
    if (rp < 1) rp = 1;
    dir = {m_hd, 16'b0} + beta[31:0];
    rotate(dir, ch, sh);
    dxp = (v * ch * dt + (64'sd1 <<< 37)) >>> 38;
    dyp = (v * sh * dt + (64'sd1 <<< 37)) >>> 38;
    m_x = sat_add(m_x, dxp);
    m_y = sat_add(m_y, dyp);
    num = v * sn * dt;
    if (num >= 0) dh = (num + rp / 2) / rp;
    else dh = -((-num + rp / 2) / rp);
    m_hd = m_hd + dh[15:0];
    p.x = m_x;
    p.y = m_y;
    p.hd = m_hd;
    return p;
  endfunction

  task automatic report_mismatch(input string what, input logic [31:0] want, input logic [31:0] got);
    $display("mismatch %s: expected %h got %h at %0t", what, want, got, $realtime);
    errors++;
  endtask

  // driver
  always @(posedge clk) begin
    if (!rst_n) begin
      in_tvalid <= 1'b0;
      in_tdata  <= '0;
    end else begin
      if (in_tvalid && in_tready) pose_q.push_back(advance_pose(in_tdata));
      if (!in_tvalid || in_tready) begin
        if (steer_q.size() > 0 && $urandom_range(99) >= in_idle_pct) begin
          in_tvalid <= 1'b1;
          in_tdata  <= steer_q.pop_front();
        end else begin
          in_tvalid <= 1'b0;
        end
      end
    end
  end

  // monitor
  always @(posedge clk) begin
    pose_t e;
    if (!rst_n) begin
      out_tready <= 1'b0;
    end else begin
      if (out_tvalid && out_tready) begin
        results_seen++;
        if (pose_q.size() == 0) begin
          report_mismatch("unexpected item", '0, out_tdata[31:0]);
        end else begin
          e = pose_q.pop_front();
          if (out_tdata[31:0] !== e.x) report_mismatch("pos_x", e.x, out_tdata[31:0]);
          if (out_tdata[63:32] !== e.y) report_mismatch("pos_y", e.y, out_tdata[63:32]);
          if (out_tdata[79:64] !== e.hd) report_mismatch("heading", e.hd, out_tdata[79:64]);
        end
      end
      if (results_seen == 100 && !hold_done) begin
        hold_done = 1;
        hold_left = 3000;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_tready <= 1'b0;
      end else begin
        out_tready <= ($urandom_range(99) >= out_idle_pct);
      end
    end
  end

  task automatic push_item(input int steer, input int speed);
    logic [14:0] s;
    logic [15:0] v;
    s = steer[14:0];
    v = speed[15:0];
    steer_q.push_back({1'b0, v, s});
  endtask

  task automatic wait_idle();
    do @(negedge clk);
    while (steer_q.size() > 0 || in_tvalid || pose_q.size() > 0);
    repeat (400) @(negedge clk);
  endtask

  task automatic write_reg(input logic [1:0] idx, input logic [15:0] val);
    @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    case (idx)
      CFG_WHEELBASE: m_wheelbase = val;
      CFG_REAR_OFS:  m_rear = val;
      default:       m_dt = val;
    endcase
  endtask

  task automatic configure(input logic [15:0] wb, input logic [15:0] ro, input logic [15:0] st);
    wait_idle();
    write_reg(CFG_WHEELBASE, wb);
    write_reg(CFG_REAR_OFS, ro);
    write_reg(CFG_STEP_TIME, st);
  endtask

  // mode 0: full random, 1: mostly fast straight driving
  task automatic push_random(input int n, input int mode);
    int st, sp;
    for (int i = 0; i < n; i++) begin
      case ($urandom_range(9))
        0: st = $urandom_range(32767) - 16384;
        1: st = ($urandom_range(1) ? 14563 : -14563);
        default: st = $urandom_range(29126) - 14563;
      endcase
      if (mode == 1 && $urandom_range(9) < 8) begin
        sp = 32767;
        st = $urandom_range(200) - 100;
      end else if ($urandom_range(7) == 0) begin
        sp = ($urandom_range(1) ? 32767 : -32768);
      end else begin
        sp = $urandom_range(65535) - 32768;
      end
      push_item(st, sp);
    end
  endtask

  initial begin
    rst_n     = 1'b0;
    cfg_we    = 1'b0;
    cfg_index = '0;
    cfg_data  = '0;
    in_tvalid = 1'b0;
    in_tdata  = '0;
    out_tready = 1'b0;
    m_wheelbase = 512;
    m_rear = 256;
    m_dt = 655;
    m_x = 0;
    m_y = 0;
    m_hd = 0;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;

    push_item(0, 0);
    push_item(14563, 32767);
    push_item(-14563, 32767);
    push_item(16383, -32768);
    push_item(-16384, 32767);
    push_item(14564, 256);
    push_item(-14564, 256);
    push_item(1, 1);
    push_item(-1, -1);
    push_item(0, 32767);
    push_item(0, -32768);
    push_item(8192, 1000);
    push_item(-8192, -1000);
    push_item(3, 1);
    push_item(16383, 32767);
    push_random(300, 0);

    configure(16'd1, 16'd0, 16'd1);
    push_random(150, 0);
    configure(16'd65535, 16'd65535, 16'd65535);
    push_random(200, 0);
    configure(16'd0, 16'd65535, 16'd40000);
    push_random(150, 0);
    configure(16'd700, 16'd300, 16'd0);
    in_idle_pct = 0;
    out_idle_pct = 0;
    push_random(150, 0);
    wait_idle();
    in_idle_pct = 33;
    out_idle_pct = 33;
    configure(16'd300, 16'd100, 16'd65535);
    push_random(400, 1);
    for (int k = 0; k < 3; k++) begin
      configure(16'($urandom_range(65535, 1)), 16'($urandom_range(65535)),
                16'($urandom_range(65535, 1)));
      push_random(100, 0);
    end
    wait_idle();

    if (errors == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

  initial begin
    #60_000_000;
    $display("status: fail");
    $finish;
  end

endmodule
